[hw/rtl/dcta_pkg.sv]
// ----------------------------------------------------------------------------
// dcta_pkg
// Shared types and constants for the duty-cycle temperature averager.
// ----------------------------------------------------------------------------
package dcta_pkg;

    // Port and field widths
    localparam int TIME_W      = 10;
    localparam int TEMP_W      = 11;
    localparam int STATUS_W    = 3;
    localparam int LIMIT_W     = 8;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 16;
    localparam int M_TUSER_W   = 3;

    // Defaults for the top-level parameters
    localparam int unsigned DEF_SAMPLES = 10;
    localparam int unsigned DEF_TIMEOUT = 1000;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd10;

    // Round accumulator
    localparam int SUM_W = 15;

    // Iterative divider
    localparam int DIVIDEND_W = 24;
    localparam int DIVISOR_W  = 11;
    localparam int DIV_STEPS  = DIVIDEND_W;

    // Duty ratio in units of 0.01 percent and conversion to tenths of a degree
    localparam int RATIO_W  = 14;
    localparam int DIFF_W   = 15;
    localparam int SCALED_W = 18;
    localparam int MAG_W    = 17;
    localparam int T_W      = 13;
    localparam logic [DIVIDEND_W-1:0]     RATIO_SCALE  = 24'd10000;
    localparam logic signed [DIFF_W-1:0]  RATIO_OFFSET = 15'sd3200;
    localparam logic signed [SCALED_W-1:0] DEG_SCALE   = 18'sd10;

    // Divide by 47: floor(m * RECIP / 2^RECIP_SHIFT), exact for m < 182361
    localparam int RECIP_W     = 17;
    localparam int RECIP_SHIFT = 22;
    localparam int PROD_W      = MAG_W + RECIP_W;
    localparam int QUO_W       = PROD_W - RECIP_SHIFT;
    localparam logic [RECIP_W-1:0] RECIP = 17'd89241;

    // Sample window, exclusive on both ends
    localparam logic signed [T_W-1:0] T_MIN = -13'sd400;
    localparam logic signed [T_W-1:0] T_MAX = 13'sd800;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        K_MEAS      = 2'd0,
        K_HIGH_MISS = 2'd1,
        K_LOW_MISS  = 2'd2
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 3'd0,
        ST_HIGH_MISSING = 3'd1,
        ST_HIGH_ALARM   = 3'd2,
        ST_LOW_MISSING  = 3'd3,
        ST_NO_SAMPLE    = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE  = 3'd0,
        S_RATIO = 3'd1,
        S_SCALE = 3'd2,
        S_ACCUM = 3'd3,
        S_ROUND = 3'd4,
        S_AVG   = 3'd5,
        S_EMIT  = 3'd6
    } state_t;

    typedef struct packed {
        kind_t             kind;
        logic [TIME_W-1:0] high_time;
        logic [TIME_W-1:0] low_time;
    } item_t;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } div_rsp_t;

endpackage

[hw/rtl/dcta_front.sv]
// ----------------------------------------------------------------------------
// dcta_front
// Input stage: takes pulse-pair beats, flags timeouts, feeds the queue.
// ----------------------------------------------------------------------------
module dcta_front
    import dcta_pkg::*;
#(
    parameter int unsigned PULSE_TIMEOUT = DEF_TIMEOUT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 push,
    output item_t                push_item,
    input  logic                 full
);

    logic              hold_valid_reg;
    logic              hold_valid_next;
    item_t             hold_item_reg;
    item_t             hold_item_next;
    logic [TIME_W-1:0] high_time;
    logic [TIME_W-1:0] low_time;
    logic              high_bad;
    logic              low_bad;
    logic              accept;

    assign high_time = s_tdata[TIME_W-1:0];
    assign low_time  = s_tdata[2*TIME_W-1:TIME_W];

    // width above the timeout counts as a timeout
    assign high_bad = (high_time == '0) || (32'(high_time) > PULSE_TIMEOUT);
    assign low_bad  = (low_time == '0) || (32'(low_time) > PULSE_TIMEOUT);

    assign push     = hold_valid_reg && !full;
    assign s_tready = !hold_valid_reg || !full;
    assign accept   = s_tvalid && s_tready;
    assign push_item = hold_item_reg;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        hold_item_next  = hold_item_reg;
        if (push)
        begin
            hold_valid_next = 1'b0;
        end
        if (accept)
        begin
            hold_valid_next          = 1'b1;
            hold_item_next.high_time = high_time;
            hold_item_next.low_time  = low_time;
            if (high_bad)
            begin
                hold_item_next.kind = K_HIGH_MISS;
            end
            else if (low_bad)
            begin
                hold_item_next.kind = K_LOW_MISS;
            end
            else
            begin
                hold_item_next.kind = K_MEAS;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_item_reg <= hold_item_next;
    end

endmodule

[hw/rtl/dcta_queue.sv]
// ----------------------------------------------------------------------------
// dcta_queue
// Short FIFO of classified items between the front and back ends.
// ----------------------------------------------------------------------------
module dcta_queue
    import dcta_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output item_t pop_item,
    output logic  empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              do_push;
    logic              do_pop;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_item = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[hw/rtl/dcta_div.sv]
// ----------------------------------------------------------------------------
// dcta_div
// Restoring divider, one quotient bit per cycle, shared by the back end.
// ----------------------------------------------------------------------------
module dcta_div
    import dcta_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int STEP_W = $clog2(DIV_STEPS + 1);

    logic                  busy_reg;
    logic                  busy_next;
    logic                  done_reg;
    logic                  done_next;
    logic [STEP_W-1:0]     step_reg;
    logic [STEP_W-1:0]     step_next;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVIDEND_W-1:0] quo_next;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  rem_next;
    logic [DIVISOR_W-1:0]  dvs_reg;
    logic [DIVISOR_W-1:0]  dvs_next;
    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    trial;
    logic                  fits;

    assign shifted = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign trial   = shifted - {1'b0, dvs_reg};
    assign fits    = (shifted >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(DIV_STEPS);
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            quo_next  = {quo_reg[DIVIDEND_W-2:0], fits};
            rem_next  = fits ? trial[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

[hw/rtl/dcta_back.sv]
// ----------------------------------------------------------------------------
// dcta_back
// Sequencer: converts pairs to samples, keeps the round and miss state,
// averages each round and holds the result beat for the output.
// ----------------------------------------------------------------------------
module dcta_back
    import dcta_pkg::*;
#(
    parameter int unsigned SAMPLES_PER_READING = DEF_SAMPLES
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    input  logic [LIMIT_W-1:0]       cfg_data,
    input  logic                     q_empty,
    input  item_t                    q_item,
    output logic                     q_pop,
    output div_req_t                 div_req,
    input  div_rsp_t                 div_rsp,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [TEMP_W-1:0] out_temp,
    output status_t                  out_status
);

    localparam int CNT_W = $clog2(SAMPLES_PER_READING + 1);
    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(SAMPLES_PER_READING);

    state_t                    state_reg;
    state_t                    state_next;
    logic [CNT_W-1:0]          idx_reg;
    logic [CNT_W-1:0]          idx_next;
    logic [CNT_W-1:0]          vc_reg;
    logic [CNT_W-1:0]          vc_next;
    logic signed [SUM_W-1:0]   sum_reg;
    logic signed [SUM_W-1:0]   sum_next;
    logic [LIMIT_W-1:0]        mc_reg;
    logic [LIMIT_W-1:0]        mc_next;
    logic [LIMIT_W-1:0]        limit_reg;
    logic [LIMIT_W-1:0]        limit_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic                      neg_reg;
    logic                      neg_next;
    logic [MAG_W-1:0]          mag_reg;
    logic [MAG_W-1:0]          mag_next;
    logic [PROD_W-1:0]         prod_reg;
    logic [PROD_W-1:0]         prod_next;
    logic signed [TEMP_W-1:0]  res_temp_reg;
    logic signed [TEMP_W-1:0]  res_temp_next;
    status_t                   res_status_reg;
    status_t                   res_status_next;
    logic signed [TEMP_W-1:0]  out_temp_reg;
    logic signed [TEMP_W-1:0]  out_temp_next;
    status_t                   out_status_reg;
    status_t                   out_status_next;

    logic                      slot_free;
    logic [LIMIT_W:0]          miss_inc;
    logic [DIVIDEND_W-1:0]     ratio_num;
    logic [DIVISOR_W-1:0]      ratio_den;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [SCALED_W-1:0] scaled;
    logic [MAG_W-1:0]          scaled_mag;
    logic [QUO_W-1:0]          t_mag;
    logic signed [T_W-1:0]     t_val;
    logic                      in_window;
    logic [SUM_W-1:0]          sum_abs;
    logic [TEMP_W-1:0]         avg_q;
    logic signed [TEMP_W-1:0]  avg_val;

    assign slot_free = !out_valid_reg || out_ready;
    assign miss_inc  = {1'b0, mc_reg} + 1'b1;
    assign ratio_num = DIVIDEND_W'(q_item.high_time) * RATIO_SCALE;
    assign ratio_den = DIVISOR_W'(q_item.high_time) + DIVISOR_W'(q_item.low_time);

    // sample = trunc(10 * (ratio - 3200) / 47), done as sign and magnitude
    assign diff       = signed'({1'b0, div_rsp.quotient[RATIO_W-1:0]}) - RATIO_OFFSET;
    assign scaled     = SCALED_W'(diff) * DEG_SCALE;
    assign scaled_mag = scaled[SCALED_W-1] ? MAG_W'(-scaled) : MAG_W'(scaled);
    assign t_mag      = prod_reg[PROD_W-1:RECIP_SHIFT];
    assign t_val      = neg_reg ? -signed'({1'b0, t_mag}) : signed'({1'b0, t_mag});
    assign in_window  = (t_val > T_MIN) && (t_val < T_MAX);

    assign sum_abs = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign avg_q   = div_rsp.quotient[TEMP_W-1:0];
    assign avg_val = neg_reg ? -signed'(avg_q) : signed'(avg_q);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    unique case (q_item.kind)
                        K_MEAS:      state_next = S_RATIO;
                        K_HIGH_MISS: state_next = S_EMIT;
                        K_LOW_MISS:  state_next = S_EMIT;
                        default:     state_next = S_IDLE;
                    endcase
                end
            end
            S_RATIO:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_SCALE;
                end
            end
            S_SCALE: state_next = S_ACCUM;
            S_ACCUM: state_next = S_ROUND;
            S_ROUND:
            begin
                if (idx_reg >= LAST_IDX)
                begin
                    state_next = (vc_reg == '0) ? S_EMIT : S_AVG;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_AVG:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        q_pop           = 1'b0;
        div_req         = '0;
        idx_next        = idx_reg;
        vc_next         = vc_reg;
        sum_next        = sum_reg;
        mc_next         = mc_reg;
        limit_next      = cfg_valid ? cfg_data : limit_reg;
        neg_next        = neg_reg;
        mag_next        = mag_reg;
        prod_next       = prod_reg;
        res_temp_next   = res_temp_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_temp_next   = out_temp_reg;
        out_status_next = out_status_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    unique case (q_item.kind)
                        K_HIGH_MISS:
                        begin
                            idx_next      = '0;
                            vc_next       = '0;
                            sum_next      = '0;
                            res_temp_next = '0;
                            if (miss_inc >= {1'b0, limit_reg})
                            begin
                                mc_next         = '0;
                                res_status_next = ST_HIGH_ALARM;
                            end
                            else
                            begin
                                mc_next         = miss_inc[LIMIT_W-1:0];
                                res_status_next = ST_HIGH_MISSING;
                            end
                        end
                        K_LOW_MISS:
                        begin
                            idx_next        = '0;
                            vc_next         = '0;
                            sum_next        = '0;
                            res_temp_next   = '0;
                            res_status_next = ST_LOW_MISSING;
                        end
                        K_MEAS:
                        begin
                            div_req.start    = 1'b1;
                            div_req.dividend = ratio_num;
                            div_req.divisor  = ratio_den;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_RATIO:
            begin
                if (div_rsp.done)
                begin
                    neg_next = scaled[SCALED_W-1];
                    mag_next = scaled_mag;
                end
            end
            S_SCALE:
            begin
                prod_next = PROD_W'(mag_reg) * PROD_W'(RECIP);
            end
            S_ACCUM:
            begin
                if (in_window)
                begin
                    sum_next = sum_reg + SUM_W'(t_val);
                    vc_next  = vc_reg + 1'b1;
                end
                idx_next = idx_reg + 1'b1;
            end
            S_ROUND:
            begin
                if (idx_reg >= LAST_IDX)
                begin
                    if (vc_reg == '0)
                    begin
                        res_temp_next   = '0;
                        res_status_next = ST_NO_SAMPLE;
                        mc_next         = '0;
                        idx_next        = '0;
                        sum_next        = '0;
                    end
                    else
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = DIVIDEND_W'(sum_abs);
                        div_req.divisor  = DIVISOR_W'(vc_reg);
                        neg_next         = sum_reg[SUM_W-1];
                    end
                end
            end
            S_AVG:
            begin
                if (div_rsp.done)
                begin
                    res_temp_next   = avg_val;
                    res_status_next = ST_OK;
                    mc_next         = '0;
                    idx_next        = '0;
                    vc_next         = '0;
                    sum_next        = '0;
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_temp_next   = res_temp_reg;
                    out_status_next = res_status_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            vc_reg        <= '0;
            sum_reg       <= '0;
            mc_reg        <= '0;
            limit_reg     <= LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            vc_reg        <= vc_next;
            sum_reg       <= sum_next;
            mc_reg        <= mc_next;
            limit_reg     <= limit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg        <= neg_next;
        mag_reg        <= mag_next;
        prod_reg       <= prod_next;
        res_temp_reg   <= res_temp_next;
        res_status_reg <= res_status_next;
        out_temp_reg   <= out_temp_next;
        out_status_reg <= out_status_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_temp   = out_temp_reg;
    assign out_status = out_status_reg;

`ifndef ASSERT_OFF
    a_err_temp_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_status_reg != ST_OK) |-> out_temp_reg == '0)
        else $error("error beat carries a nonzero temperature");

    a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (vc_reg <= idx_reg) && (idx_reg <= LAST_IDX))
        else $error("round counters out of range");

    a_alarm_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) && (res_status_reg == ST_HIGH_ALARM) |-> mc_reg == '0)
        else $error("miss counter not cleared after alarm");

    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |=> (state_reg == S_RATIO) || (state_reg == S_AVG))
        else $error("divider started outside a divide step");
`endif

endmodule

[hw/rtl/duty_cycle_temperature_averager_core.sv]
// ----------------------------------------------------------------------------
// duty_cycle_temperature_averager_core
// Flow: a timeout pair gives a status beat without a divide. A measured
//   pair waits on the shared 24-step divider; the last pair of a round
//   waits on it again for the average if any of its samples fell in the
//   window. The back end takes one pair at a time; the front and a 2-deep
//   queue take pairs meanwhile.
// Reset: asynchronous, active low; clears round, miss counter, queue and the
//   output beat, and loads the alarm limit with 10.
// ----------------------------------------------------------------------------
module duty_cycle_temperature_averager_core
    import dcta_pkg::*;
#(
    parameter int unsigned SAMPLES_PER_READING = DEF_SAMPLES,
    parameter int unsigned PULSE_TIMEOUT       = DEF_TIMEOUT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [9:0] high_time, [19:10] low_time
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [10:0] temperature_tenths
    output logic [M_TUSER_W-1:0] m_tuser,   // [2:0] status
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [LIMIT_W-1:0]   cfg_data
);

    logic                     push;
    item_t                    push_item;
    logic                     full;
    logic                     pop;
    item_t                    pop_item;
    logic                     empty;
    div_req_t                 div_req;
    div_rsp_t                 div_rsp;
    logic signed [TEMP_W-1:0] out_temp;
    status_t                  out_status;

    assign cfg_ready = 1'b1;

    dcta_front #(
        .PULSE_TIMEOUT (PULSE_TIMEOUT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .push      (push),
        .push_item (push_item),
        .full      (full)
    );

    dcta_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (empty)
    );

    dcta_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    dcta_back #(
        .SAMPLES_PER_READING (SAMPLES_PER_READING)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .q_empty    (empty),
        .q_item     (pop_item),
        .q_pop      (pop),
        .div_req    (div_req),
        .div_rsp    (div_rsp),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_temp   (out_temp),
        .out_status (out_status)
    );

    assign m_tdata = {{(M_TDATA_W - TEMP_W){1'b0}}, out_temp};
    assign m_tuser = out_status;

endmodule

[tb/sv/dcta_checker.sv]
// ----------------------------------------------------------------------------
// dcta_checker
// Watches the pulse-pair, reading and limit channels of the averager. Folds
// every accepted pair into its own copy of the round state, queues the
// reading that pair should produce, and compares each reading beat with the
// oldest queued one.
// ----------------------------------------------------------------------------
module dcta_checker
    import dcta_pkg::*;
#(
    parameter int unsigned SAMPLES = DEF_SAMPLES,
    parameter int unsigned TIMEOUT = DEF_TIMEOUT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [9:0] high_time, [19:10] low_time
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,   // [10:0] temperature_tenths
    input  logic [M_TUSER_W-1:0] m_tuser,   // [2:0] status
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [LIMIT_W-1:0]   cfg_data,
    output int                   fail_count,
    output int                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // duty in units of 0.01 percent, conversion to tenths of a degree
    localparam int DUTY_FULL   = 10000;
    localparam int DUTY_OFFSET = 3200;
    localparam int TENTHS_MUL  = 10;
    localparam int TENTHS_DIV  = 47;
    localparam int WINDOW_LO   = -400;
    localparam int WINDOW_HI   = 800;

    typedef struct packed {
        logic [TEMP_W-1:0] temp;
        status_t           status;
    } reading_t;

    reading_t          expected_readings[$];
    logic [LIMIT_W-1:0] alarm_limit;
    int unsigned       pair_count;
    int unsigned       good_count;
    int                sum_tenths;
    int unsigned       miss_run;
    int                mismatches;

    task automatic queue_reading(input int temp, input status_t status);
        reading_t r;
        r.temp   = TEMP_W'(temp);
        r.status = status;
        expected_readings.push_back(r);
    endtask

    task automatic clear_round();
        pair_count = 0;
        good_count = 0;
        sum_tenths = 0;
    endtask

    task automatic fold_pulse_pair(input logic [TIME_W-1:0] hi, input logic [TIME_W-1:0] lo);
        int duty;
        int tenths;
        if (hi == 0 || hi > TIMEOUT) begin
            clear_round();
            miss_run = (miss_run + 1) & 9'h1FF;
            if (miss_run >= alarm_limit) begin
                miss_run = 0;
                queue_reading(0, ST_HIGH_ALARM);
            end
            else
                queue_reading(0, ST_HIGH_MISSING);
        end
        else if (lo == 0 || lo > TIMEOUT) begin
            clear_round();
            queue_reading(0, ST_LOW_MISSING);
        end
        else begin
            duty   = (DUTY_FULL * int'(hi)) / (int'(hi) + int'(lo));
            tenths = ((duty - DUTY_OFFSET) * TENTHS_MUL) / TENTHS_DIV;
            if (tenths > WINDOW_LO && tenths < WINDOW_HI) begin
                sum_tenths += tenths;
                good_count = (good_count + 1) & 4'hF;
            end
            pair_count = (pair_count + 1) & 4'hF;
            if (pair_count >= SAMPLES) begin
                if (good_count == 0)
                    queue_reading(0, ST_NO_SAMPLE);
                else
                    queue_reading(sum_tenths / int'(good_count), ST_OK);
                miss_run = 0;
                clear_round();
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        reading_t want;
        if (!rst_n) begin
            alarm_limit = LIMIT_RESET;
            miss_run    = 0;
            mismatches  = 0;
            clear_round();
            expected_readings.delete();
        end
        else begin
            if (cfg_valid && cfg_ready)
                alarm_limit = cfg_data;
            if (s_tvalid && s_tready)
                fold_pulse_pair(s_tdata[TIME_W-1:0], s_tdata[2*TIME_W-1:TIME_W]);
            if (m_tvalid && m_tready) begin
                if (expected_readings.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected reading beat, expected none, got tdata=%h tuser=%0d",
                             $time, m_tdata, m_tuser);
                end
                else begin
                    want = expected_readings.pop_front();
                    if (m_tdata !== M_TDATA_W'(want.temp)) begin
                        mismatches++;
                        $display("%0t: temperature expected %0d (tdata=%h) got tdata=%h",
                                 $time, $signed(want.temp), M_TDATA_W'(want.temp), m_tdata);
                    end
                    if (m_tuser !== want.status) begin
                        mismatches++;
                        $display("%0t: status expected %0d got %0d",
                                 $time, want.status, m_tuser);
                    end
                end
            end
        end
        fail_count <= mismatches;
        pending    <= expected_readings.size();
    end

endmodule

[tb/sv/tb_duty_cycle_temperature_averager_core.sv]
// ----------------------------------------------------------------------------
// tb_duty_cycle_temperature_averager_core
// Drives pulse pairs into the averager with random gaps and back-pressure,
// steps the miss alarm limit through several values while idle, and reports
// the verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module tb_duty_cycle_temperature_averager_core
    import dcta_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SAMPLES = DEF_SAMPLES;
    localparam int unsigned TIMEOUT = DEF_TIMEOUT;
    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 6;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 200;
    localparam int DRAIN_CYCLES   = 120;
    localparam int PRESSURE_PAIRS = 8;
    localparam int TIME_MAX       = (1 << TIME_W) - 1;
    localparam int PAD_W          = S_TDATA_W - 2 * TIME_W;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [LIMIT_W-1:0]   cfg_data;

    int fail_count;
    int pending;
    int items_sent;
    int limit_now;
    int idle_cycles;
    bit src_idle_on;
    bit stall_on;
    bit hold_pending;

    // first round ends with an average, then an aborted round, misses of
    // every kind, and a round whose samples all fall outside the window
    int directed_hi[26] = '{1000, 1, 1000, 696, 132, 500, 300, 600, 250, 400,
                            450, 0, 1023, 500, 0, 500,
                            1, 1000, 50, 980, 10, 990, 100, 900, 20, 950};
    int directed_lo[26] = '{1000, 1000, 1, 304, 868, 500, 700, 400, 750, 600,
                            550, 500, 500, 1001, 0, 0,
                            1000, 1, 950, 20, 990, 10, 900, 100, 980, 50};

    duty_cycle_temperature_averager_core #(
        .SAMPLES_PER_READING (SAMPLES),
        .PULSE_TIMEOUT       (TIMEOUT)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    dcta_checker #(
        .SAMPLES (SAMPLES),
        .TIMEOUT (TIMEOUT)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // no beat on any channel for too long means the block hung
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else if (roll < 98)
            return $urandom_range(4, 20);
        else
            return $urandom_range(50, 200);
    endfunction

    // reading sink: random stalls, plus one long hold-off on request
    initial
    begin : sink
        int run;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_pending) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                m_tready <= 1'b1;
                hold_pending = 1'b0;
            end
            else if (stall_on && $urandom_range(0, 3) == 0) begin
                run = pick_gap() + 1;
                m_tready <= 1'b0;
                repeat (run) @(negedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic send_pair(input int hi, input int lo);
        int gap;
        gap = src_idle_on ? pick_gap() : 0;
        @(negedge clk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{PAD_W{1'b0}}, TIME_W'(lo), TIME_W'(hi)};
        do @(posedge clk); while (!s_tready);
        items_sent++;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        // pairs that give no reading may still be in flight
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input int value);
        wait_idle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= LIMIT_W'(value);
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        limit_now = value;
    endtask

    // aims for a duty inside the sample window, random total period
    task automatic good_pair(output int hi, output int lo);
        int duty;
        int period;
        duty   = $urandom_range(1321, 6959);
        period = $urandom_range(20, TIMEOUT);
        hi = (period * duty) / 10000;
        if (hi < 1)
            hi = 1;
        lo = period - hi;
        if (lo < 1)
            lo = 1;
    endtask

    task automatic outside_pair(output int hi, output int lo);
        if ($urandom_range(0, 1)) begin
            hi = $urandom_range(1, 100);
            lo = $urandom_range(900, TIMEOUT);
        end
        else begin
            hi = $urandom_range(900, TIMEOUT);
            lo = $urandom_range(1, 100);
        end
    endtask

    task automatic send_high_miss();
        int hi;
        hi = $urandom_range(0, 1) ? 0 : $urandom_range(TIMEOUT + 1, TIME_MAX);
        send_pair(hi, $urandom_range(0, TIME_MAX));
    endtask

    task automatic send_low_miss();
        int lo;
        lo = $urandom_range(0, 1) ? 0 : $urandom_range(TIMEOUT + 1, TIME_MAX);
        send_pair($urandom_range(1, TIMEOUT), lo);
    endtask

    task automatic send_round();
        int kind;
        int cut;
        int hi;
        int lo;
        kind = $urandom_range(0, 99);
        cut  = (kind < 5) ? $urandom_range(0, SAMPLES - 1) : SAMPLES;
        for (int k = 0; k < cut; k++) begin
            if (kind < 65 || (kind < 90 && $urandom_range(0, 9) < 7))
                good_pair(hi, lo);
            else if (kind < 90) begin
                hi = $urandom_range(1, TIMEOUT);
                lo = $urandom_range(1, TIMEOUT);
            end
            else
                outside_pair(hi, lo);
            send_pair(hi, lo);
        end
        if (cut < SAMPLES) begin
            if ($urandom_range(0, 1))
                send_high_miss();
            else
                send_low_miss();
        end
    endtask

    task automatic send_miss_burst();
        int n;
        n = $urandom_range(1, limit_now + 1);
        repeat (n)
        begin
            if ($urandom_range(0, 99) < 85)
                send_high_miss();
            else
                send_low_miss();
        end
    endtask

    task automatic run_phase(input int limit, input int pairs);
        int target;
        int roll;
        write_limit(limit);
        send_high_miss();
        target = items_sent + pairs;
        while (items_sent < target)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 70)
                send_round();
            else if (roll < 82) begin
                repeat ($urandom_range(1, 4))
                    send_pair($urandom_range(0, TIME_MAX), $urandom_range(0, TIME_MAX));
            end
            else if (roll < 92)
                send_miss_burst();
            else if (roll < 96)
                send_high_miss();
            else
                send_low_miss();
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        items_sent   = 0;
        limit_now    = LIMIT_RESET;
        src_idle_on  = 1'b1;
        stall_on     = 1'b1;
        hold_pending = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_hi[i])
            send_pair(directed_hi[i], directed_lo[i]);

        run_phase(1, 200);

        // sink holds off while misses arrive back to back: block must fill up
        src_idle_on  = 1'b0;
        hold_pending = 1'b1;
        repeat (PRESSURE_PAIRS) send_high_miss();
        src_idle_on  = 1'b1;

        run_phase(255, 250);
        run_phase(0, 200);

        src_idle_on = 1'b0;
        stall_on    = 1'b0;
        run_phase(10, 250);
        src_idle_on = 1'b1;
        stall_on    = 1'b1;

        run_phase(2, 250);
        run_phase($urandom_range(1, 255), 250);
        run_phase($urandom_range(1, 255), 250);

        @(negedge clk);
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
